@@ src/swz_pkg.sv @@
// shared types and constants for the strided window zeroing block
// no dependencies; imported by every module under src

package swz_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_COLS = 3'd0,
    REG_FRAME_ROWS = 3'd1,
    REG_FIRST_COL  = 3'd2,
    REG_COL_STEP   = 3'd3,
    REG_COL_COUNT  = 3'd4,
    REG_FIRST_ROW  = 3'd5,
    REG_ROW_STEP   = 3'd6,
    REG_ROW_COUNT  = 3'd7
  } reg_idx_e;

  localparam logic [CFG_W-1:0] RST_FRAME_SIZE = 16'd1;
  localparam logic [CFG_W-1:0] RST_FIRST      = 16'd0;
  localparam logic [CFG_W-1:0] RST_STEP       = 16'd1;
  localparam logic [CFG_W-1:0] RST_COUNT      = 16'd0;

  // settings of one axis
  typedef struct packed {
    logic [CFG_W-1:0] size;
    logic [CFG_W-1:0] first;
    logic [CFG_W-1:0] step;
    logic [CFG_W-1:0] count;
  } axis_cfg_t;

  typedef struct packed {
    axis_cfg_t col;
    axis_cfg_t row;
  } cfg_t;

  // what one axis reports for the current position
  typedef struct packed {
    logic hit;
    logic last;
  } axis_status_t;

endpackage

@@ src/strided_window_zeroing_top.sv @@
// top level of the strided window zeroing block
// depends on swz_pkg, swz_cfg_regs, swz_axis, swz_out_stage
//
// Samples of a frame arrive in row-major order on the slave stream, one per
// beat. Each beat leaves on the master stream with the same sample, or zero
// when its column and its row both fall on a strided window point; tuser
// flags a zeroed sample and tlast marks the last sample of a frame. Frames
// repeat without a restart.
// The result is registered: a beat taken at one edge is offered on the master
// side from the next. Throughput is one beat per cycle while the receiver
// takes beats, set by the single result register, which accepts a new beat in
// the same cycle its previous beat is taken.
// When the receiver stalls, the result register holds its beat and s tready
// drops until it is taken; nothing is lost or repeated.
// Reset clears the position counters and loads the default registers:
// one-by-one frame, window disabled. Registers are written through the
// plain write port and take effect at once; write them between frames.

module strided_window_zeroing_top #(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned COORD_WIDTH  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [swz_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [swz_pkg::CFG_W-1:0]     cfg_data_i,
  // slave stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [SAMPLE_WIDTH-1:0]       s_axis_tdata_i,   // [31:0] sample_in
  // master stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [SAMPLE_WIDTH-1:0]       m_axis_tdata_o,   // [31:0] sample_out
  output logic                          m_axis_tuser_o,   // [0] was_zeroed
  output logic                          m_axis_tlast_o    // frame_end
);
  import swz_pkg::*;

  cfg_t         cfg;
  axis_status_t col_st, row_st;
  logic         space, accept;

  assign s_axis_tready_o = space;
  assign accept          = s_axis_tvalid_i && space;

  swz_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  swz_axis #(.COORD_WIDTH(COORD_WIDTH)) u_col (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg.col),
    .advance_i (accept),
    .status_o  (col_st)
  );

  // rows move only when the column counter wraps
  swz_axis #(.COORD_WIDTH(COORD_WIDTH)) u_row (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg.row),
    .advance_i (accept && col_st.last),
    .status_o  (row_st)
  );

  swz_out_stage #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept),
    .sample_i        (s_axis_tdata_i),
    .zero_i          (col_st.hit && row_st.hit),
    .frame_end_i     (col_st.last && row_st.last),
    .space_o         (space),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  a_zeroed_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("zeroed beat carries nonzero data");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("accepted beat produced no result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while result register is stalled");

  a_wrap_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && col_st.last && row_st.last
    |=> m_axis_tlast_o)
    else $error("frame end not flagged on last sample");

endmodule

@@ src/swz_cfg_regs.sv @@
// configuration register file of the strided window zeroing block
// depends on swz_pkg

module swz_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swz_pkg::REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [swz_pkg::CFG_W-1:0]           cfg_data_i,
  output swz_pkg::cfg_t                       cfg_o
);
  import swz_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_FRAME_COLS: cfg_d.col.size  = cfg_data_i;
        REG_FRAME_ROWS: cfg_d.row.size  = cfg_data_i;
        REG_FIRST_COL:  cfg_d.col.first = cfg_data_i;
        REG_COL_STEP:   cfg_d.col.step  = cfg_data_i;
        REG_COL_COUNT:  cfg_d.col.count = cfg_data_i;
        REG_FIRST_ROW:  cfg_d.row.first = cfg_data_i;
        REG_ROW_STEP:   cfg_d.row.step  = cfg_data_i;
        REG_ROW_COUNT:  cfg_d.row.count = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.col.size  <= RST_FRAME_SIZE;
      cfg_q.col.first <= RST_FIRST;
      cfg_q.col.step  <= RST_STEP;
      cfg_q.col.count <= RST_COUNT;
      cfg_q.row.size  <= RST_FRAME_SIZE;
      cfg_q.row.first <= RST_FIRST;
      cfg_q.row.step  <= RST_STEP;
      cfg_q.row.count <= RST_COUNT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/swz_axis.sv @@
// position, stride phase and hit counters of one frame axis
// depends on swz_pkg

module swz_axis #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  swz_pkg::axis_cfg_t     cfg_i,
  input  logic                   advance_i,
  output swz_pkg::axis_status_t  status_o
);
  import swz_pkg::*;

  localparam int unsigned CMP_W = ((COORD_WIDTH > CFG_W) ? COORD_WIDTH : CFG_W) + 1;

  logic [COORD_WIDTH-1:0] pos_q, pos_d;
  logic [COORD_WIDTH-1:0] phase_q, phase_d;
  logic [COORD_WIDTH-1:0] hits_q, hits_d;

  logic [CMP_W-1:0] pos_x, pos_inc_x, phase_inc_x, hits_x;
  logic [CMP_W-1:0] size_x, first_x, step_x, count_x;
  logic [COORD_WIDTH-1:0] phase_inc;
  logic at_first, last;

  always_comb begin
    // zero size or zero stride behaves as one
    size_x  = (cfg_i.size == '0) ? CMP_W'(1) : {{(CMP_W-CFG_W){1'b0}}, cfg_i.size};
    step_x  = (cfg_i.step == '0) ? CMP_W'(1) : {{(CMP_W-CFG_W){1'b0}}, cfg_i.step};
    first_x = {{(CMP_W-CFG_W){1'b0}}, cfg_i.first};
    count_x = {{(CMP_W-CFG_W){1'b0}}, cfg_i.count};

    pos_x     = {{(CMP_W-COORD_WIDTH){1'b0}}, pos_q};
    pos_inc_x = pos_x + CMP_W'(1);
    hits_x    = {{(CMP_W-COORD_WIDTH){1'b0}}, hits_q};

    phase_inc   = COORD_WIDTH'(phase_q + 1'b1);
    phase_inc_x = {{(CMP_W-COORD_WIDTH){1'b0}}, phase_inc};

    at_first = (pos_x >= first_x);
    last     = (pos_inc_x >= size_x);

    status_o.last = last;
    status_o.hit  = at_first && (phase_q == '0) && (hits_x < count_x);

    pos_d   = pos_q;
    phase_d = phase_q;
    hits_d  = hits_q;
    if (advance_i) begin
      if (last) begin
        pos_d   = '0;
        phase_d = '0;
        hits_d  = '0;
      end else begin
        if (at_first) begin
          if (phase_inc_x >= step_x) begin
            phase_d = '0;
            // hit count saturates at all ones
            if (hits_q != '1) hits_d = COORD_WIDTH'(hits_q + 1'b1);
          end else begin
            phase_d = phase_inc;
          end
        end
        pos_d = COORD_WIDTH'(pos_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= '0;
      hits_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      hits_q  <= hits_d;
    end
  end

endmodule

@@ src/swz_out_stage.sv @@
// result register with zeroing mux on the master side of the block
// depends on swz_pkg

module swz_out_stage #(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                    zero_i,
  input  logic                    frame_end_i,
  output logic                    space_o,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [SAMPLE_WIDTH-1:0] m_axis_tdata_o,
  output logic                    m_axis_tuser_o,
  output logic                    m_axis_tlast_o
);
  import swz_pkg::*;

  logic                    valid_q, valid_d;
  logic [SAMPLE_WIDTH-1:0] data_q;
  logic                    zero_q, last_q;

  // register is free when empty or its beat leaves this cycle
  assign space_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (m_axis_tready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= zero_i ? '0 : sample_i;
      zero_q <= zero_i;
      last_q <= frame_end_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = zero_q;
  assign m_axis_tlast_o  = last_q;

endmodule

@@ verif/strided_window_zeroing_top_tb.sv @@
// testbench for strided_window_zeroing_top: directed frames, back-pressure and random traffic
// checks every output beat against an in-bench model; depends on swz_pkg and the rtl top
`timescale 1ns / 1ps

module strided_window_zeroing_top_tb;
  import swz_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 570;  // per idling phase

  typedef struct packed {
    logic [31:0] sample;
    logic        zeroed;
    logic        last;
  } beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [31:0]          s_axis_tdata_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [31:0]          m_axis_tdata_o;
  logic                 m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  strided_window_zeroing_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [31:0] sample_in
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [31:0] sample_out
    .m_axis_tuser_o  (m_axis_tuser_o),   // [0] was_zeroed
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // model copy of the registers and axis counters
  logic [15:0] regs_q [8];
  logic [15:0] col_pos, row_pos, col_phase, col_hits, row_phase, row_hits;

  beat_t expected_beats[$];
  int    errors = 0;
  int    beats_seen = 0;
  int    zeroed_seen = 0;
  int    frames_seen = 0;
  int    input_stalls = 0;
  int    cycles = 0;
  int    src_idle_pct = 0;
  int    sink_idle_pct = 0;
  int    stall_request = 0;
  int    stall_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic on_stride(input logic [15:0] pos, first, phase, hits, count);
    return (pos >= first) && (phase == 16'd0) && (hits < count);
  endfunction

  // move one axis forward, returns 1 when it wraps to zero
  function automatic logic advance_axis(inout logic [15:0] pos, phase, hits,
                                        input logic [15:0] size, first, stride);
    logic [15:0] p;
    logic [15:0] st;
    st = at_least_one(stride);
    if ({1'b0, pos} + 17'd1 >= {1'b0, at_least_one(size)}) begin
      pos = '0;
      phase = '0;
      hits = '0;
      return 1'b1;
    end
    if (pos >= first) begin
      p = phase + 16'd1;
      if (p >= st) begin
        p = '0;
        if (hits != 16'hffff) hits = hits + 16'd1;
      end
      phase = p;
    end
    pos = pos + 16'd1;
    return 1'b0;
  endfunction

  function automatic beat_t predict_zeroing(input logic [31:0] sample);
    beat_t b;
    logic  hit;
    logic  last_col, last_row;
    hit = on_stride(col_pos, regs_q[REG_FIRST_COL], col_phase, col_hits, regs_q[REG_COL_COUNT])
       && on_stride(row_pos, regs_q[REG_FIRST_ROW], row_phase, row_hits, regs_q[REG_ROW_COUNT]);
    last_col = {1'b0, col_pos} + 17'd1 >= {1'b0, at_least_one(regs_q[REG_FRAME_COLS])};
    last_row = {1'b0, row_pos} + 17'd1 >= {1'b0, at_least_one(regs_q[REG_FRAME_ROWS])};
    b.sample = hit ? 32'd0 : sample;
    b.zeroed = hit;
    b.last   = last_col && last_row;
    if (advance_axis(col_pos, col_phase, col_hits, regs_q[REG_FRAME_COLS],
                     regs_q[REG_FIRST_COL], regs_q[REG_COL_STEP]))
      void'(advance_axis(row_pos, row_phase, row_hits, regs_q[REG_FRAME_ROWS],
                         regs_q[REG_FIRST_ROW], regs_q[REG_ROW_STEP]));
    return b;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_sample(input logic [31:0] sample);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= sample;
    @(posedge clk_i);
    while (!s_axis_tready_o) begin
      input_stalls++;
      @(posedge clk_i);
    end
    expected_beats.push_back(predict_zeroing(sample));
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    regs_q[idx] = value;
  endtask

  task automatic program_axes(input logic [15:0] cols, rows, fc, cs, cc, fr, rs, rc);
    write_reg(REG_FRAME_COLS, cols);
    write_reg(REG_FRAME_ROWS, rows);
    write_reg(REG_FIRST_COL, fc);
    write_reg(REG_COL_STEP, cs);
    write_reg(REG_COL_COUNT, cc);
    write_reg(REG_FIRST_ROW, fr);
    write_reg(REG_ROW_STEP, rs);
    write_reg(REG_ROW_COUNT, rc);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // mostly small frames and windows, with the register extremes now and then
  function automatic logic [15:0] pick_size();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hffff;
      default: return 16'($urandom_range(1, 9));
    endcase
  endfunction

  function automatic logic [15:0] pick_first(input logic [15:0] size);
    if ($urandom_range(9) == 0) return 16'hffff;
    return 16'($urandom_range(0, (size > 16'd12) ? 12 : size));
  endfunction

  function automatic logic [15:0] pick_stride();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hffff;
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [15:0] pick_count();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hffff;
      default: return 16'($urandom_range(1, 5));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    // one-by-one frames, window off: every beat passes and ends a frame
    send_sample(32'h0000_0000);
    send_sample(32'hffff_ffff);
    send_sample(32'h5a5a_a5a5);
    wait_drained();
  endtask

  task automatic test_full_window();
    program_axes(16'd2, 16'd2, 16'd0, 16'd1, 16'hffff, 16'd0, 16'd1, 16'hffff);
    repeat (2) send_sample(32'hffff_ffff);
    send_sample(32'ha5a5_5a5a);
    send_sample(32'h0000_0001);
    wait_drained();
  endtask

  task automatic test_zero_sizes();
    // zero sizes and zero strides behave as one
    program_axes(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1);
    send_sample(32'h8000_0000);
    send_sample(32'h7fff_ffff);
    wait_drained();
  endtask

  task automatic test_window_past_frame();
    // second stride point lies beyond the row, it must not spill into the next one
    program_axes(16'd4, 16'd2, 16'd2, 16'd3, 16'd5, 16'd0, 16'd1, 16'd2);
    repeat (8) send_sample(rand_sample());
    wait_drained();
  endtask

  task automatic test_shrink_mid_frame();
    program_axes(16'd8, 16'd1, 16'd1, 16'd2, 16'd3, 16'd0, 16'd1, 16'd1);
    repeat (5) send_sample(rand_sample());
    wait_drained();
    // column now past the new size, wraps on the next advance
    write_reg(REG_FRAME_COLS, 16'd3);
    cfg_we_i <= 1'b0;
    repeat (2) send_sample(rand_sample());
    wait_drained();
  endtask

  task automatic test_backpressure();
    program_axes(16'd3, 16'd2, 16'd1, 16'd1, 16'd2, 16'd1, 16'd1, 16'd1);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    stall_request = 80;
    repeat (30) send_sample(rand_sample());
    wait_drained();
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n);
    int left;
    int seg;
    logic [15:0] cols, rows;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    left = n;
    while (left > 0) begin
      wait_drained();
      cols = pick_size();
      rows = pick_size();
      program_axes(cols, rows, pick_first(cols), pick_stride(), pick_count(),
                   pick_first(rows), pick_stride(), pick_count());
      seg = $urandom_range(30, 110);
      if (seg > left) seg = left;
      repeat (seg) send_sample(rand_sample());
      left -= seg;
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------- receiver and checker

  always @(posedge clk_i) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_beat
    beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat data %h user %b last %b", $time,
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (want.zeroed) zeroed_seen++;
        if (want.last) frames_seen++;
        if (m_axis_tdata_o !== want.sample) begin
          $display("%0t: sample_out expected %h got %h", $time, want.sample, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tuser_o !== want.zeroed) begin
          $display("%0t: was_zeroed expected %b got %b", $time, want.zeroed, m_axis_tuser_o);
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $display("%0t: frame_end expected %b got %b", $time, want.last, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $time, expected_beats.size());
      $display("strided_window_zeroing_top_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    regs_q[REG_FRAME_COLS] = RST_FRAME_SIZE;
    regs_q[REG_FRAME_ROWS] = RST_FRAME_SIZE;
    regs_q[REG_FIRST_COL]  = RST_FIRST;
    regs_q[REG_COL_STEP]   = RST_STEP;
    regs_q[REG_COL_COUNT]  = RST_COUNT;
    regs_q[REG_FIRST_ROW]  = RST_FIRST;
    regs_q[REG_ROW_STEP]   = RST_STEP;
    regs_q[REG_ROW_COUNT]  = RST_COUNT;
    {col_pos, row_pos, col_phase, col_hits, row_phase, row_hits} = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_full_window();
    test_zero_sizes();
    test_window_past_frame();
    test_shrink_mid_frame();
    test_backpressure();
    test_random_traffic(35, 48, RANDOM_ITEMS);
    test_random_traffic(48, 35, RANDOM_ITEMS);
    test_random_traffic(0, 0, RANDOM_ITEMS);

    repeat (10) @(posedge clk_i);
    $display("covered %0d beats over many window settings: %0d zeroed, %0d frame ends",
             beats_seen, zeroed_seen, frames_seen);
    $display("input held off for %0d cycles under back-pressure, %0d errors",
             input_stalls, errors);
    if (errors == 0) begin
      $display("strided_window_zeroing_top_tb: PASS");
    end else begin
      $display("strided_window_zeroing_top_tb: FAIL");
    end
    $finish;
  end

endmodule
